// ===== hw/rtl/dmhs_pkg.sv =====
// Shared types, limits and digit split for the dual-mode h:m:s stopwatch.
package dmhs_pkg;

  localparam logic [5:0] SecMax   = 6'd59;
  localparam logic [5:0] MinMax   = 6'd59;
  localparam logic [6:0] HourMax  = 7'd99;
  localparam logic [6:0] HourWrap = 7'd100;
  localparam int unsigned NumAdj  = 6;

  // Adjust latch order
  localparam int unsigned AdjIncSec = 0;
  localparam int unsigned AdjDecSec = 1;
  localparam int unsigned AdjIncMin = 2;
  localparam int unsigned AdjDecMin = 3;
  localparam int unsigned AdjIncHr  = 4;
  localparam int unsigned AdjDecHr  = 5;

  typedef struct packed {
    logic tick;
    logic clear;
    logic pause;
    logic resume;
    logic mode_button;
    logic inc_seconds_button;
    logic dec_seconds_button;
    logic inc_minutes_button;
    logic dec_minutes_button;
    logic inc_hours_button;
    logic dec_hours_button;
  } dmhs_in_t;

  typedef struct packed {
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [2:0] min_tens;
    logic [3:0] hour_ones;
    logic [3:0] hour_tens;
    logic       counting_down;
    logic       buzzer;
    logic       running;
  } dmhs_out_t;

  typedef struct packed {
    logic [5:0]        seconds;
    logic [5:0]        minutes;
    logic [6:0]        hours;
    logic              down_mode;
    logic              run_flag;
    logic              buzzer_on;
    logic              mode_prev;
    logic [NumAdj-1:0] adj_latch;
  } dmhs_state_t;

  // Split 0..99 into tens (upper nibble) and ones (lower nibble).
  // Tens by reciprocal multiply: (v * 205) >> 11 is exact for v < 1029.
  function automatic logic [7:0] bcd_split(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  rem;
    prod = {8'd0, v} * 15'd205;
    q    = prod[14:11];
    rem  = v - {q[3:0], 3'b000} - {2'b00, q[3:0], 1'b0};
    return {q, rem[3:0]};
  endfunction

endpackage

// ===== hw/rtl/dmhs_next.sv =====
// Next-state logic: clear, pause/resume, tick carry or borrow, mode and adjusts.
module dmhs_next
  import dmhs_pkg::*;
(
  input  dmhs_state_t state_i,
  input  dmhs_in_t    item_i,
  output dmhs_state_t state_o
);

  logic [NumAdj-1:0] press;
  logic [NumAdj-1:0] edge_hit;

  assign press = {item_i.dec_hours_button, item_i.inc_hours_button,
                  item_i.dec_minutes_button, item_i.inc_minutes_button,
                  item_i.dec_seconds_button, item_i.inc_seconds_button};
  assign edge_hit = press & ~state_i.adj_latch;

  always_comb begin
    dmhs_state_t s;
    s = state_i;

    if (item_i.clear) begin
      s.seconds = '0;
      s.minutes = '0;
      s.hours   = '0;
    end
    if (item_i.pause) s.run_flag = 1'b0;
    if (item_i.resume) begin
      s.run_flag  = 1'b1;
      s.buzzer_on = 1'b0;
    end

    if (item_i.tick && s.run_flag) begin
      if (!s.down_mode) begin
        s.buzzer_on = 1'b0;
        s.seconds   = s.seconds + 6'd1;
        if (s.seconds > SecMax) begin
          s.seconds = '0;
          s.minutes = s.minutes + 6'd1;
        end
        if (s.minutes > MinMax) begin
          s.minutes = '0;
          s.hours   = s.hours + 7'd1;
        end
        if (s.hours >= HourWrap) begin
          s.hours   = '0;
          s.minutes = '0;
          s.seconds = '0;
        end
      end else if (s.seconds != '0) begin
        s.seconds = s.seconds - 6'd1;
      end else if (s.minutes != '0) begin
        s.minutes = s.minutes - 6'd1;
        s.seconds = SecMax;
      end else if (s.hours != '0) begin
        s.hours   = s.hours - 7'd1;
        s.minutes = MinMax;
        s.seconds = SecMax;
      end else begin
        s.buzzer_on = 1'b1;
      end
    end

    if (item_i.mode_button && !state_i.mode_prev) s.down_mode = !s.down_mode;
    s.mode_prev = item_i.mode_button;

    // Adjusts in latch order; increments saturate, decrements stop at zero
    if (edge_hit[AdjIncSec] && s.seconds < SecMax) s.seconds = s.seconds + 6'd1;
    if (edge_hit[AdjDecSec] && s.seconds != '0)    s.seconds = s.seconds - 6'd1;
    if (edge_hit[AdjIncMin] && s.minutes < MinMax) s.minutes = s.minutes + 6'd1;
    if (edge_hit[AdjDecMin] && s.minutes != '0)    s.minutes = s.minutes - 6'd1;
    if (edge_hit[AdjIncHr] && s.hours < HourMax)   s.hours   = s.hours + 7'd1;
    if (edge_hit[AdjDecHr] && s.hours != '0)       s.hours   = s.hours - 7'd1;
    s.adj_latch = press;

    state_o = s;
  end

endmodule

// ===== hw/rtl/dual_mode_hms_stopwatch.sv =====
// Top level of the dual-mode hours/minutes/seconds stopwatch and countdown timer.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one beat per clock sample:
//   the one-second tick, clear/pause/resume pulses and the levels of the mode
//   button and six adjust buttons. Every input beat yields exactly one result
//   beat on the output channel (out_valid/out_stall/out_data): six BCD digits
//   plus direction, buzzer and running flags, showing the state after the beat.
//   A beat taken sits in the input register; as it moves on it updates the
//   count and its result goes into the result register, shown on out_*.
//   Throughput: one beat per cycle while out_stall is low; the next beat is
//   taken while a result waits: input and result registers part the two sides.
//   When the receiver stalls, the result register holds; at most one more beat is
//   taken into the input register, then in_stall rises until the result drains.
//   Reset: count 00:00:00, counting up, running, buzzer off, all buttons
//   treated as released; both registers empty.
//   Press edges are taken between successive beats, not between clocks.
module dual_mode_hms_stopwatch
  import dmhs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dmhs_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output dmhs_out_t out_data
);

  logic        s1_valid_r;
  dmhs_in_t    s1_data_r;
  dmhs_state_t state_r;
  dmhs_state_t state_nxt;
  logic        out_valid_r;
  dmhs_out_t   out_data_r;
  logic        out_free;
  logic        s1_fire;
  logic [7:0]  sec_bcd;
  logic [7:0]  min_bcd;
  logic [7:0]  hour_bcd;

  // Result register can take a beat when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  // Hold the input side only when the staged beat cannot move on
  assign in_stall = s1_valid_r && !out_free;

  // Input register: take a beat whenever it is empty or moving forward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // Count, flags and press latches advance once per staged beat
  dmhs_next u_next (
    .state_i (state_r),
    .item_i  (s1_data_r),
    .state_o (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.seconds   <= '0;
      state_r.minutes   <= '0;
      state_r.hours     <= '0;
      state_r.down_mode <= 1'b0;
      state_r.run_flag  <= 1'b1;
      state_r.buzzer_on <= 1'b0;
      state_r.mode_prev <= 1'b0;
      state_r.adj_latch <= '0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // Split the new count into BCD digits for the result
  assign sec_bcd  = bcd_split({1'b0, state_nxt.seconds});
  assign min_bcd  = bcd_split({1'b0, state_nxt.minutes});
  assign hour_bcd = bcd_split(state_nxt.hours);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r.sec_ones      <= sec_bcd[3:0];
      out_data_r.sec_tens      <= sec_bcd[6:4];
      out_data_r.min_ones      <= min_bcd[3:0];
      out_data_r.min_tens      <= min_bcd[6:4];
      out_data_r.hour_ones     <= hour_bcd[3:0];
      out_data_r.hour_tens     <= hour_bcd[7:4];
      out_data_r.counting_down <= state_nxt.down_mode;
      out_data_r.buzzer        <= state_nxt.buzzer_on;
      out_data_r.running       <= state_nxt.run_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Minutes and seconds never leave 0..59
  a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.seconds <= SecMax) && (state_r.minutes <= MinMax))
    else $error("minutes or seconds out of range");

  // Hours never leave 0..99
  a_hr_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.hours <= HourMax)
    else $error("hours out of range");

  // A staged beat that moves on always lands in the result register
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("staged beat lost");

endmodule

// ===== tb/sv/dual_mode_hms_stopwatch_tb.sv =====
// Self-checking testbench for the dual-mode h:m:s stopwatch, predicting every result beat.
module dual_mode_hms_stopwatch_tb;
  import dmhs_pkg::*;

  localparam int unsigned StuckLimit  = 2000; // cycles with no beat moving on either side
  localparam int unsigned RandomBeats = 750;
  localparam int unsigned QuietTail   = 120;  // final random beats with no idling at all
  localparam int unsigned DrainCycles = 8;    // margin after the last expected result, for strays
  localparam int unsigned MaxPrinted  = 30;

  typedef enum int {SegClimb, SegDescend, SegCount, SegNoise} segment_t;

  // Tracks the stopwatch state beat by beat and holds the displays it should show.
  class display_scoreboard;
    logic [5:0]        secs;
    logic [5:0]        mins;
    logic [6:0]        hours;
    logic              down;
    logic              run;
    logic              buzz;
    logic              mode_prev;
    logic [NumAdj-1:0] latch;
    dmhs_out_t         expected_displays[$];
    int unsigned       errors;

    function new();
      secs      = '0;
      mins      = '0;
      hours     = '0;
      down      = 1'b0;
      run       = 1'b1;
      buzz      = 1'b0;
      mode_prev = 1'b0;
      latch     = '0;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return expected_displays.size();
    endfunction

    task report(string msg);
      if (errors < MaxPrinted) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want) report($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    function void tick_up();
      buzz = 1'b0;
      secs = secs + 6'd1;
      if (secs > SecMax) begin
        secs = '0;
        mins = mins + 6'd1;
      end
      if (mins > MinMax) begin
        mins  = '0;
        hours = hours + 7'd1;
      end
      if (hours >= HourWrap) begin
        hours = '0;
        mins  = '0;
        secs  = '0;
      end
    endfunction

    function void tick_down();
      if (secs != 0) begin
        secs = secs - 6'd1;
      end else if (mins != 0) begin
        mins = mins - 6'd1;
        secs = SecMax;
      end else if (hours != 0) begin
        hours = hours - 7'd1;
        mins  = MinMax;
        secs  = SecMax;
      end else begin
        buzz = 1'b1;
      end
    endfunction

    // Step one unit up to a ceiling, or down to zero.
    function int nudge(int v, bit up, int top);
      if (up) return (v < top) ? v + 1 : v;
      return (v != 0) ? v - 1 : v;
    endfunction

    task note_beat(dmhs_in_t b);
      logic [NumAdj-1:0] press;
      dmhs_out_t         want;
      press[AdjIncSec] = b.inc_seconds_button;
      press[AdjDecSec] = b.dec_seconds_button;
      press[AdjIncMin] = b.inc_minutes_button;
      press[AdjDecMin] = b.dec_minutes_button;
      press[AdjIncHr]  = b.inc_hours_button;
      press[AdjDecHr]  = b.dec_hours_button;
      if (b.clear) begin
        secs  = '0;
        mins  = '0;
        hours = '0;
      end
      if (b.pause) run = 1'b0;
      if (b.resume) begin
        run  = 1'b1;
        buzz = 1'b0;
      end
      if (b.tick && run) begin
        if (down) tick_down();
        else tick_up();
      end
      if (b.mode_button && !mode_prev) down = !down;
      mode_prev = b.mode_button;
      for (int i = 0; i < NumAdj; i++) begin
        if (press[i] && !latch[i]) begin
          case (i)
            AdjIncSec, AdjDecSec: secs  = 6'(nudge(secs, i == AdjIncSec, SecMax));
            AdjIncMin, AdjDecMin: mins  = 6'(nudge(mins, i == AdjIncMin, MinMax));
            default:              hours = 7'(nudge(hours, i == AdjIncHr, HourMax));
          endcase
        end
      end
      latch = press;
      want.sec_ones      = 4'(secs % 10);
      want.sec_tens      = 3'(secs / 10);
      want.min_ones      = 4'(mins % 10);
      want.min_tens      = 3'(mins / 10);
      want.hour_ones     = 4'(hours % 10);
      want.hour_tens     = 4'(hours / 10);
      want.counting_down = down;
      want.buzzer        = buzz;
      want.running       = run;
      expected_displays.push_back(want);
    endtask

    task check_result(dmhs_out_t got);
      dmhs_out_t want;
      if (expected_displays.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = expected_displays.pop_front();
      compare_field("sec_ones", got.sec_ones, want.sec_ones);
      compare_field("sec_tens", got.sec_tens, want.sec_tens);
      compare_field("min_ones", got.min_ones, want.min_ones);
      compare_field("min_tens", got.min_tens, want.min_tens);
      compare_field("hour_ones", got.hour_ones, want.hour_ones);
      compare_field("hour_tens", got.hour_tens, want.hour_tens);
      compare_field("counting_down", got.counting_down, want.counting_down);
      compare_field("buzzer", got.buzzer, want.buzzer);
      compare_field("running", got.running, want.running);
    endtask
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  dmhs_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  dmhs_out_t   out_data;

  bit          quiet       = 1'b0; // no idling on either side
  bit          calm        = 1'b0; // idle-free stretch within the random part
  int unsigned stall_left  = 0;
  int unsigned stuck_cycles = 0;

  display_scoreboard board;

  dual_mode_hms_stopwatch dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit one_in(int unsigned n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  // Offer one beat, starting and ending at a falling edge. Valid is left high
  // afterwards so back-to-back beats never drop it; an idle burst, if drawn,
  // lowers it first. Hold the payload until the block takes it.
  task automatic send_beat(input dmhs_in_t b);
    if (!quiet && !calm && one_in(6)) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Receiver: stall in random bursts; no new burst starts in quiet or calm spells.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  = 1'b1;
      stall_left = stall_left - 1;
    end else if (!quiet && !calm && one_in(10)) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Sample both channels at the rising edge: predict on every input beat taken,
  // check every result beat taken, and count cycles in which nothing moved.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_beat(in_data);
      if (out_valid && !out_stall) board.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  // Watchdog: give up once the handshakes have been silent for too long.
  initial begin
    while (stuck_cycles < StuckLimit) @(negedge clk);
    $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
             StuckLimit, board.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    dmhs_in_t    b;
    segment_t    kind;
    int unsigned sent;
    int unsigned seg_len;

    board = new();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed beats: reset display, ticks, single and held presses.
    b = '0;
    send_beat(b);
    b.tick = 1'b1;
    send_beat(b);                                   // 00:00:01
    b = '0;
    b.inc_seconds_button = 1'b1;
    send_beat(b);                                   // press edge: 00:00:02
    b.tick = 1'b1;
    send_beat(b);                                   // held button: tick only
    b = '0;
    b.dec_seconds_button = 1'b1;
    send_beat(b);
    b = '0;
    b.dec_minutes_button = 1'b1;
    send_beat(b);                                   // decrement at zero does nothing
    send_beat(b);                                   // and holding it does not act later
    b = '0;
    b.inc_minutes_button = 1'b1;
    b.inc_hours_button   = 1'b1;
    send_beat(b);
    b = '0;
    b.dec_minutes_button = 1'b1;
    b.dec_hours_button   = 1'b1;
    send_beat(b);
    // Pause takes effect before the tick in the same beat.
    b = '0;
    b.pause = 1'b1;
    b.tick  = 1'b1;
    send_beat(b);
    b = '0;
    b.tick = 1'b1;
    send_beat(b);                                   // paused: tick dropped
    b.resume = 1'b1;
    send_beat(b);                                   // resume then count
    b = '0;
    b.mode_button = 1'b1;
    send_beat(b);                                   // switch to down
    b.tick = 1'b1;
    send_beat(b);                                   // held mode, count down
    // Down tick at zero sounds the buzzer and holds the count.
    b = '0;
    b.clear = 1'b1;
    b.tick  = 1'b1;
    send_beat(b);
    b.clear = 1'b0;
    send_beat(b);
    b = '0;
    b.pause  = 1'b1;
    b.resume = 1'b1;
    send_beat(b);                                   // both at once: resume wins
    b = '0;
    b.tick = 1'b1;
    send_beat(b);                                   // buzzer on again
    b = '0;
    b.mode_button = 1'b1;
    send_beat(b);                                   // back to up, buzzer held
    b = '0;
    b.tick = 1'b1;
    send_beat(b);                                   // up tick silences the buzzer
    b = '0;
    b.pause = 1'b1;
    send_beat(b);
    b = '0;
    b.tick = 1'b1;
    send_beat(b);                                   // paused tick, buzzer untouched
    b = '0;
    b.resume = 1'b1;
    send_beat(b);
    b = '1;
    send_beat(b);                                   // every input at once
    b = '0;
    send_beat(b);

    // Random part in segments: climb and descend hammer the adjust buttons to
    // reach the ceilings and zero, count segments mostly tick so that wraps and
    // the buzzer follow, and noise segments throw in arbitrary beats.
    sent = 0;
    while (sent < RandomBeats) begin
      kind = segment_t'($urandom_range(0, 3));
      calm = one_in(4);
      case (kind)
        SegClimb, SegDescend: seg_len = $urandom_range(40, 260);
        SegCount:             seg_len = $urandom_range(20, 80);
        default:              seg_len = $urandom_range(10, 40);
      endcase
      repeat (seg_len) begin
        if (sent >= RandomBeats) break;
        quiet = (sent >= RandomBeats - QuietTail);
        case (kind)
          SegClimb: begin
            b.inc_seconds_button = b.inc_seconds_button ^ !one_in(4);
            b.inc_minutes_button = b.inc_minutes_button ^ !one_in(4);
            b.inc_hours_button   = b.inc_hours_button ^ !one_in(4);
            b.dec_seconds_button = one_in(16);
            b.dec_minutes_button = one_in(16);
            b.dec_hours_button   = one_in(16);
            b.tick               = one_in(4);
          end
          SegDescend: begin
            b.dec_seconds_button = b.dec_seconds_button ^ !one_in(4);
            b.dec_minutes_button = b.dec_minutes_button ^ !one_in(4);
            b.dec_hours_button   = b.dec_hours_button ^ !one_in(4);
            b.inc_seconds_button = one_in(16);
            b.inc_minutes_button = one_in(16);
            b.inc_hours_button   = one_in(16);
            b.tick               = one_in(4);
          end
          SegCount: begin
            b.inc_seconds_button = one_in(24);
            b.dec_seconds_button = one_in(24);
            b.inc_minutes_button = one_in(24);
            b.dec_minutes_button = one_in(24);
            b.inc_hours_button   = one_in(24);
            b.dec_hours_button   = one_in(24);
            b.tick               = !one_in(8);
          end
          default: b = dmhs_in_t'(11'($urandom()));
        endcase
        if (kind != SegNoise) begin
          // Keep clears out of the adjust runs so that the ceilings are reached.
          b.clear  = (kind == SegCount) && one_in(40);
          b.pause  = one_in(24);
          b.resume = one_in(12);
          b.mode_button = b.mode_button ^ one_in(16);
        end
        send_beat(b);
        sent++;
      end
    end
    calm = 1'b0;
    in_valid = 1'b0;

    // Drain: wait for every expected display, then a little longer for strays.
    while (board.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (board.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dmhs_pkg.sv
hw/rtl/dmhs_next.sv
hw/rtl/dual_mode_hms_stopwatch.sv
tb/sv/dual_mode_hms_stopwatch_tb.sv
